### hw/rtl/pida_pkg.sv
// ----------------------------------------------------------------------------
// Positional insert/delete array package
// Shared widths, codes and transfer types for the array block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pida_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int OP_W     = 2;
  localparam int POS_W    = 7;
  localparam int ELEM_W   = 32;
  localparam int IDX_W    = 6;
  localparam int STAT_W   = 2;
  localparam int CNTO_W   = 7;

  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int IN_DATA_W  = ((POS_W + ELEM_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ELEM_W + IDX_W + STAT_W + CNTO_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TRAVERSE = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    op_t                     op;
    logic [POS_W-1:0]        position;
    logic signed [ELEM_W-1:0] element;
  } request_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic [IDX_W-1:0]        index;
    status_t                 status;
    logic [CNTO_W-1:0]       count;
    logic                    last;
  } result_t;

endpackage

### hw/rtl/pida_core.sv
// ----------------------------------------------------------------------------
// Positional insert/delete array sequencer
// Element memory (one write, one registered read port), moved one element
// per cycle by a small sequencer: inserts, deletes, traverses while res_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pida_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  output logic                req_ready,
  input  pida_pkg::request_t  req,
  output logic                res_valid,
  input  logic                res_ready,
  output pida_pkg::result_t   res
);
  import pida_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SHINS = 6'b000010,
    S_PUT   = 6'b000100,
    S_SHDEL = 6'b001000,
    S_TRAV  = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic [CNT_W-1:0]         pos_r, pos_nxt;
  logic signed [ELEM_W-1:0] val_r, val_nxt;
  status_t                  status_r, status_nxt;

  logic signed [ELEM_W-1:0] mem [CAPACITY];
  logic signed [ELEM_W-1:0] rdata_r;
  logic                     we, re;
  logic [ADDR_W-1:0]        waddr, raddr;
  logic signed [ELEM_W-1:0] wdata;

  logic [CMP_W-1:0]         req_pos, cur_cnt;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign req_pos = CMP_W'(req.position);
  assign cur_cnt = CMP_W'(count_r);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = ADDR_W'(idx_r);
    raddr      = ADDR_W'(idx_r);
    wdata      = rdata_r;
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          pos_nxt    = CNT_W'(req.position);
          val_nxt    = req.element;
          status_nxt = ST_OK;
          state_nxt  = S_RESP;
          case (req.op)
            OP_INSERT: begin
              if (req_pos > cur_cnt) begin
                status_nxt = ST_BADPOS;
              end else if (count_r == CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else if (req_pos == cur_cnt) begin
                state_nxt = S_PUT;
              end else begin
                re        = 1'b1;
                raddr     = ADDR_W'(count_r - CNT_W'(1));
                idx_nxt   = count_r;
                state_nxt = S_SHINS;
              end
            end
            OP_DELETE: begin
              if (req_pos >= cur_cnt) begin
                status_nxt = ST_BADPOS;
              end else if (req_pos + CMP_W'(1) < cur_cnt) begin
                re        = 1'b1;
                raddr     = ADDR_W'(req_pos + CMP_W'(1));
                idx_nxt   = CNT_W'(req.position);
                state_nxt = S_SHDEL;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            OP_TRAVERSE: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                re        = 1'b1;
                raddr     = '0;
                idx_nxt   = '0;
                state_nxt = S_TRAV;
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_SHINS: begin
        we = 1'b1;
        if (idx_r > pos_r + CNT_W'(1)) begin
          re      = 1'b1;
          raddr   = ADDR_W'(idx_r - CNT_W'(2));
          idx_nxt = idx_r - CNT_W'(1);
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        we        = 1'b1;
        waddr     = ADDR_W'(pos_r);
        wdata     = val_r;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_RESP;
      end
      S_SHDEL: begin
        we = 1'b1;
        if ((CMP_W + 1)'(idx_r) + (CMP_W + 1)'(2) < (CMP_W + 1)'(count_r)) begin
          re      = 1'b1;
          raddr   = ADDR_W'(idx_r + CNT_W'(2));
          idx_nxt = idx_r + CNT_W'(1);
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_RESP;
        end
      end
      S_TRAV: begin
        if (res_ready) begin
          if (idx_r + CNT_W'(1) == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            re      = 1'b1;
            raddr   = ADDR_W'(idx_r + CNT_W'(1));
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
  end

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_TRAV) || (state_r == S_RESP);

  always_comb begin
    res.count = CNTO_W'(count_r);
    if (state_r == S_TRAV) begin
      res.element = rdata_r;
      res.index   = IDX_W'(idx_r);
      res.status  = ST_OK;
      res.last    = (idx_r + CNT_W'(1) == count_r);
    end else begin
      res.element = '0;
      res.index   = '0;
      res.status  = status_r;
      res.last    = 1'b1;
    end
  end

endmodule

### hw/rtl/positional_insert_delete_array.sv
// ----------------------------------------------------------------------------
// Positional insert/delete array
// Ordered array of signed elements with insert, delete and traverse by
// position, behind stream channels with a registered result stage.
// ----------------------------------------------------------------------------
//   Channel  Direction  tdata (low bit up)                        tuser  tlast
//   in_      slave      position, element_in                      op     -
//   out_     master     element_out, element_index, status, count -      last
//
// Insert at position p shifts the stored elements from p up one place and
// then writes the new element; delete shifts the elements above p down one
// place. The single memory write port moves one element a cycle. Error and
// op 3 results skip the shifts. A traverse reads the elements in order from
// 0, each as the output takes the one before. Reset empties the array at
// once; memory contents are not cleared. A stalled out_ channel holds the
// result register and pauses the sequencer in its result and traverse states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_insert_delete_array (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // position [6:0], element_in [38:7]
  input  logic [pida_pkg::IN_DATA_W-1:0]       in_tdata,
  // op [1:0]
  input  logic [pida_pkg::OP_W-1:0]            in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // element_out [31:0], element_index [37:32], status [39:38], count_out [46:40]
  output logic [pida_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tlast
);
  import pida_pkg::*;

  request_t req;
  result_t  res;
  result_t  res_r;
  logic     res_valid, res_ready;
  logic     out_valid_r;

  assign req.op       = op_t'(in_tuser);
  assign req.position = in_tdata[POS_W-1:0];
  assign req.element  = in_tdata[POS_W+ELEM_W-1:POS_W];

  pida_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = res_r.last;
  assign out_tdata  = OUT_DATA_W'({res_r.count, res_r.status, res_r.index, res_r.element});

endmodule

### test/tb_positional_insert_delete_array.sv
// ----------------------------------------------------------------------------
// Testbench for the positional insert/delete array
// A queue-fed driver offers insert, delete, traverse and unused-op requests
// on the in_ stream. A shadow copy of the array predicts every result, and a
// monitor on the out_ stream checks each transfer field by field. Both sides
// idle at random, with one long stall on the result side. The stimulus fills
// the array to capacity and then drains it again.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_positional_insert_delete_array;
  import pida_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_LEN     = 400;
  localparam int IDLE_PCT     = 11;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]       in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  request_t    pending_requests[$];
  result_t     awaited_results[$];
  request_t    on_bus;
  int unsigned requests_total    = 0;
  int unsigned requests_accepted = 0;
  int unsigned results_seen      = 0;
  int unsigned mismatches        = 0;
  int unsigned cycle_count       = 0;
  int unsigned hold_cycles       = 0;
  bit          hold_done         = 1'b0;
  bit          steady;

  // Shadow copy of the array contents and count.
  logic signed [ELEM_W-1:0] held_elements [CAPACITY];
  int                       held_count = 0;

  // Count as seen by the stimulus generator, to aim positions.
  int                       planned_count = 0;

  positional_insert_delete_array dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  assign steady = (cycle_count >= 300) && (cycle_count < 1300);

  function automatic result_t make_result(logic signed [ELEM_W-1:0] element,
                                          int index, status_t status, bit last);
    result_t r;
    r.element = element;
    r.index   = index[IDX_W-1:0];
    r.status  = status;
    r.count   = held_count[CNTO_W-1:0];
    r.last    = last;
    return r;
  endfunction

  // Update the shadow array for one request and queue the results it causes.
  task automatic apply_request(request_t req);
    int pos;
    pos = int'(req.position);
    case (req.op)
      OP_INSERT: begin
        if (pos > held_count) begin
          awaited_results.push_back(make_result('0, 0, ST_BADPOS, 1'b1));
        end else if (held_count >= CAPACITY) begin
          awaited_results.push_back(make_result('0, 0, ST_FULL, 1'b1));
        end else begin
          for (int i = held_count; i > pos; i--) held_elements[i] = held_elements[i-1];
          held_elements[pos] = req.element;
          held_count++;
          awaited_results.push_back(make_result('0, 0, ST_OK, 1'b1));
        end
      end
      OP_DELETE: begin
        if (pos >= held_count) begin
          awaited_results.push_back(make_result('0, 0, ST_BADPOS, 1'b1));
        end else begin
          for (int i = pos; i + 1 < held_count; i++) held_elements[i] = held_elements[i+1];
          held_count--;
          awaited_results.push_back(make_result('0, 0, ST_OK, 1'b1));
        end
      end
      OP_TRAVERSE: begin
        if (held_count == 0) begin
          awaited_results.push_back(make_result('0, 0, ST_EMPTY, 1'b1));
        end else begin
          for (int i = 0; i < held_count; i++)
            awaited_results.push_back(make_result(held_elements[i], i, ST_OK,
                                                  i + 1 == held_count));
        end
      end
      default: begin
        awaited_results.push_back(make_result('0, 0, ST_OK, 1'b1));
      end
    endcase
  endtask

  task automatic queue_request(op_t op, int pos, logic [ELEM_W-1:0] value);
    request_t req;
    req.op       = op;
    req.position = pos[POS_W-1:0];
    req.element  = value;
    pending_requests.push_back(req);
    requests_total++;
    if (op == OP_INSERT && pos <= planned_count && planned_count < CAPACITY)
      planned_count++;
    else if (op == OP_DELETE && pos < planned_count)
      planned_count--;
  endtask

  // One random request; the weights steer the count up, down or neither.
  task automatic queue_random(int ins_ok, int ins_bad, int del_ok, int del_bad,
                              int trav);
    int r;
    r = $urandom_range(99);
    if (r < ins_ok)
      queue_request(OP_INSERT, $urandom_range(planned_count, 0), $urandom);
    else if (r < ins_ok + ins_bad)
      queue_request(OP_INSERT, $urandom_range(127, planned_count + 1), $urandom);
    else if (r < ins_ok + ins_bad + del_ok && planned_count > 0)
      queue_request(OP_DELETE, $urandom_range(planned_count - 1, 0), $urandom);
    else if (r < ins_ok + ins_bad + del_ok + del_bad)
      queue_request(OP_DELETE, $urandom_range(127, planned_count), $urandom);
    else if (r < ins_ok + ins_bad + del_ok + del_bad + trav)
      queue_request(OP_TRAVERSE, $urandom_range(127), $urandom);
    else
      queue_request(OP_NONE, $urandom_range(127), $urandom);
  endtask

  task automatic build_stimulus();
    queue_request(OP_TRAVERSE, 0, 32'h0);
    queue_request(OP_DELETE, 0, 32'h0);
    queue_request(OP_INSERT, 1, 32'h1234_5678);
    queue_request(OP_NONE, 127, 32'hFFFF_FFFF);
    queue_request(OP_INSERT, 0, 32'h7FFF_FFFF);
    queue_request(OP_INSERT, 1, 32'h8000_0000);
    queue_request(OP_INSERT, 0, 32'hFFFF_FFFF);
    queue_request(OP_INSERT, 1, 32'h0000_0000);
    queue_request(OP_INSERT, 127, 32'h5555_5555);
    queue_request(OP_TRAVERSE, 127, 32'hFFFF_FFFF);
    queue_request(OP_DELETE, 127, 32'h0);
    queue_request(OP_DELETE, 4, 32'h0);
    queue_request(OP_DELETE, 3, 32'h0);
    queue_request(OP_DELETE, 0, 32'h0);
    queue_request(OP_TRAVERSE, 0, 32'h0);
    queue_request(OP_INSERT, 2, 32'hAAAA_AAAA);
    queue_request(OP_DELETE, 1, 32'h0);
    queue_request(OP_NONE, 0, 32'h0);
    queue_request(OP_TRAVERSE, 0, 32'h0);

    // Fill to capacity, then probe the full array.
    while (planned_count < CAPACITY) queue_random(78, 6, 7, 2, 3);
    queue_request(OP_INSERT, $urandom_range(CAPACITY, 0), $urandom);
    queue_request(OP_INSERT, CAPACITY, $urandom);
    queue_request(OP_INSERT, $urandom_range(127, CAPACITY + 1), $urandom);
    queue_request(OP_TRAVERSE, 0, $urandom);
    queue_request(OP_DELETE, CAPACITY, $urandom);

    // Drain to empty, then a mixed tail.
    while (planned_count > 0) queue_random(10, 4, 72, 6, 4);
    queue_request(OP_TRAVERSE, 0, $urandom);
    repeat (20) queue_random(35, 10, 30, 10, 10);
    queue_request(OP_TRAVERSE, 0, $urandom);
  endtask

  // Driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_request(on_bus);
        requests_accepted <= requests_accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          on_bus = pending_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {{(IN_DATA_W - ELEM_W - POS_W){1'b0}}, on_bus.element, on_bus.position};
          in_tuser  <= on_bus.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready, including one long hold-off once results are flowing.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 40) begin
      hold_done   <= 1'b1;
      hold_cycles <= HOLD_LEN;
      out_tready  <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    result_t                  want;
    logic signed [ELEM_W-1:0] got_element;
    logic [IDX_W-1:0]         got_index;
    logic [STAT_W-1:0]        got_status;
    logic [CNTO_W-1:0]        got_count;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      got_element = $signed(out_tdata[31:0]);
      got_index   = out_tdata[37:32];
      got_status  = out_tdata[39:38];
      got_count   = out_tdata[46:40];
      if (awaited_results.size() == 0) begin
        $error("result transfer with no result awaited: element_out %0d status %0d",
               got_element, got_status);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (got_element !== want.element) begin
          $error("element_out: expected %0d, got %0d", want.element, got_element);
          mismatches++;
        end
        if (got_index !== want.index) begin
          $error("element_index: expected %0d, got %0d", want.index, got_index);
          mismatches++;
        end
        if (got_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got_status);
          mismatches++;
        end
        if (got_count !== want.count) begin
          $error("count_out: expected %0d, got %0d", want.count, got_count);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    bit finished;
    finished = 1'b0;
    build_stimulus();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    fork
      begin
        while (requests_accepted < requests_total) @(posedge clk);
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        finished = 1'b1;
      end
      begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
      end
    join_any
    if (finished && mismatches == 0 && awaited_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
